FILE: rtl/adcm_pkg.sv
// ---------------------------------------------------------------------------
// adcm_pkg
// Shared types and constants for the two-channel ADC scan / median block.
// ---------------------------------------------------------------------------
package adcm_pkg;

   // Sample width is fixed by the converter reading field
   localparam int SAMPLE_BITS = 10;
   localparam int HISTORY_DEPTH_DEFAULT = 5;
   localparam int SETTLE_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [SETTLE_BITS-1:0] SETTLE_TICKS_RESET = SETTLE_BITS'(2);
   localparam logic [SAMPLE_BITS-1:0] FAULT_THRESHOLD_RESET = SAMPLE_BITS'(50);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

   // Channel codes
   localparam logic CHANNEL_BOTTOM = 1'b0;
   localparam logic CHANNEL_HEATER = 1'b1;

   // Register indexes on the csr port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SETTLE_TICKS    = 2'd0,
      CSR_FAULT_THRESHOLD = 2'd1
   } csr_index_type;

   // Input transaction
   typedef struct packed {
      logic                   conv_done;
      logic [SAMPLE_BITS-1:0] adc_reading;
      logic                   median_select;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic                   start_conversion;
      logic                   channel;
      logic                   reading_taken;
      logic [SAMPLE_BITS-1:0] median_value;
      logic [SAMPLE_BITS-1:0] bottom_min;
      logic [SAMPLE_BITS-1:0] bottom_max;
      logic [SAMPLE_BITS-1:0] heater_min;
      logic [SAMPLE_BITS-1:0] heater_max;
      logic                   fault;
   } rsp_type;

   // Top level sequencer
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LAUNCH = 4'b0010,
      ST_SORT   = 4'b0100,
      ST_EMIT   = 4'b1000
   } top_state_type;

   // Median selector sequencer
   typedef enum logic [1:0] {
      MED_IDLE = 2'b01,
      MED_SCAN = 2'b10
   } med_state_type;

   // Control from the top level to the median selector
   typedef struct packed {
      logic start;
   } med_ctrl_type;

   // Status from the median selector
   typedef struct packed {
      logic busy;
      logic done;
   } med_stat_type;

endpackage

FILE: rtl/adcm_median.sv
// ---------------------------------------------------------------------------
// adcm_median
// Rank selector: finds the middle element of a small ring with one shared
// comparator. Each pass takes one candidate and compares it against every
// other entry as the working copy rotates past a fixed tap.
// ---------------------------------------------------------------------------
module adcm_median #(
   parameter int DEPTH = adcm_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  adcm_pkg::med_ctrl_type         ctrl,
   input  logic [adcm_pkg::SAMPLE_BITS-1:0] ring_data [DEPTH],
   output adcm_pkg::med_stat_type         stat,
   output logic [adcm_pkg::SAMPLE_BITS-1:0] median_value
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = IW + 1;

   adcm_pkg::med_state_type state_ff, state_in;
   logic [adcm_pkg::SAMPLE_BITS-1:0] work_ff [DEPTH];
   logic [adcm_pkg::SAMPLE_BITS-1:0] work_in [DEPTH];
   logic [adcm_pkg::SAMPLE_BITS-1:0] cand_ff, cand_in;
   logic [adcm_pkg::SAMPLE_BITS-1:0] median_ff, median_in;
   logic [IW-1:0] step_ff, step_in;
   logic [IW-1:0] pass_ff, pass_in;
   logic [IW-1:0] count_ff, count_in;
   logic          done_ff, done_in;

   logic [adcm_pkg::SAMPLE_BITS-1:0] cand_cur;
   logic [SW-1:0] order_sum;
   logic          tie_later;
   logic          less;
   logic          last_step;
   logic [IW-1:0] count_next;

   // Shared comparator: tap entry 0 against the current candidate
   always_comb begin
      cand_cur   = (step_ff == '0) ? work_ff[0] : cand_ff;
      order_sum  = {1'b0, pass_ff} + {1'b0, step_ff};
      // tap entry sits before the candidate in ring order when the sum wraps
      tie_later  = (order_sum >= SW'(DEPTH));
      less       = (step_ff != '0) &&
                   ((work_ff[0] < cand_cur) || ((work_ff[0] == cand_cur) && tie_later));
      count_next = ((step_ff == '0) ? '0 : count_ff) + IW'(less);
      last_step  = (step_ff == IW'(DEPTH - 1));
   end

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      work_in   = work_ff;
      cand_in   = cand_ff;
      median_in = median_ff;
      step_in   = step_ff;
      pass_in   = pass_ff;
      count_in  = count_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         adcm_pkg::MED_IDLE: begin
            if (ctrl.start) begin
               work_in  = ring_data;
               step_in  = '0;
               pass_in  = '0;
               count_in = '0;
               state_in = adcm_pkg::MED_SCAN;
            end
         end
         adcm_pkg::MED_SCAN: begin
            cand_in  = cand_cur;
            count_in = count_next;
            // rotate by one, by two on the last step so the next pass
            // starts on the next candidate
            for (int i = 0; i < DEPTH; i++) begin
               work_in[i] = last_step ? work_ff[(i + 2) % DEPTH] : work_ff[(i + 1) % DEPTH];
            end
            if (last_step) begin
               step_in = '0;
               if ((count_next == IW'(DEPTH / 2)) || (pass_ff == IW'(DEPTH - 1))) begin
                  median_in = cand_cur;
                  done_in   = 1'b1;
                  state_in  = adcm_pkg::MED_IDLE;
               end else begin
                  pass_in = pass_ff + IW'(1);
               end
            end else begin
               step_in = step_ff + IW'(1);
            end
         end
         default: begin
            state_in = adcm_pkg::MED_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adcm_pkg::MED_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
         pass_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
         pass_ff  <= pass_in;
         count_ff <= count_in;
      end
   end

   // Data registers
   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      cand_ff   <= cand_in;
      median_ff <= median_in;
   end

   assign stat.busy    = (state_ff == adcm_pkg::MED_SCAN);
   assign stat.done    = done_ff;
   assign median_value = median_ff;

   // Checks
   a_done_after_scan: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff == adcm_pkg::MED_SCAN))
      else $error("median done without a scan");

   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == adcm_pkg::MED_SCAN) && (step_ff != '0) |-> $past(state_ff == adcm_pkg::MED_SCAN))
      else $error("scan step advanced outside a scan");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == adcm_pkg::MED_SCAN) |-> (pass_ff <= IW'(DEPTH - 1)))
      else $error("candidate pass out of range");

endmodule

FILE: rtl/two_channel_adc_scan_median.sv
// ---------------------------------------------------------------------------
// two_channel_adc_scan_median
// Scans a bottom and a heater channel on millisecond ticks, keeps a history
// ring and min/max per channel, and reports the median of a chosen ring.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one tick transaction (conv_done, adc_reading, median_select)
//   and is taken when req_valid is high and req_stall is low. rsp_* returns
//   exactly one result transaction per tick. csr_* writes settle_ticks
//   (index 0) and fault_threshold (index 1); the user must write them only
//   while the block is idle, which the block itself does not enforce.
// Sequencing:
//   An accepted tick passes through ST_LAUNCH, ST_SORT and ST_EMIT before
//   its result is loaded. The sort is paced by the single comparator in
//   the median selector, which checks one candidate/entry pair per cycle
//   and stops on the pass that finds the middle rank. req_stall is high
//   until the result is loaded; no new tick is taken before then.
// Reset:
//   Synchronous, active high. Rings clear to zero, minimums to full scale,
//   maximums to zero, countdown to 2, threshold to 50, fault clear.
// Receiver stall:
//   The result sits in an output register; the next tick can be accepted
//   while it waits, but its result is held back until rsp_stall drops.
// ---------------------------------------------------------------------------
module two_channel_adc_scan_median #(
   parameter int HISTORY_DEPTH = adcm_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  adcm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output adcm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_en,
   input  logic [adcm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [adcm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int SB = adcm_pkg::SAMPLE_BITS;
   localparam int TB = adcm_pkg::SETTLE_BITS;

   // Sequencer and handshake state
   adcm_pkg::top_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   adcm_pkg::rsp_type       rsp_ff, rsp_in;

   // Configuration
   logic [TB-1:0] settle_ticks_ff, settle_ticks_in;
   logic [SB-1:0] threshold_ff, threshold_in;

   // Scan state
   logic          channel_ff, channel_in;
   logic [TB-1:0] settle_count_ff, settle_count_in;
   logic [SB-1:0] bottom_ring_ff [HISTORY_DEPTH];
   logic [SB-1:0] bottom_ring_in [HISTORY_DEPTH];
   logic [SB-1:0] heater_ring_ff [HISTORY_DEPTH];
   logic [SB-1:0] heater_ring_in [HISTORY_DEPTH];
   logic [IW-1:0] ring_index_ff, ring_index_in;
   logic [SB-1:0] min_ff [2];
   logic [SB-1:0] min_in [2];
   logic [SB-1:0] max_ff [2];
   logic [SB-1:0] max_in [2];
   logic          fault_ff, fault_in;

   // Per-tick flags held for the result
   logic start_ff, start_in;
   logic taken_ff, taken_in;
   logic select_ff, select_in;

   logic accept;
   logic store;
   logic [SB-1:0] median_ring [HISTORY_DEPTH];
   logic [SB-1:0] median_value;
   adcm_pkg::med_ctrl_type med_ctrl;
   adcm_pkg::med_stat_type med_stat;

   assign req_stall = (state_ff != adcm_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Configuration writes
   always_comb begin
      settle_ticks_in = settle_ticks_ff;
      threshold_in    = threshold_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            adcm_pkg::CSR_SETTLE_TICKS: begin
               settle_ticks_in = csr_wdata[TB-1:0];
            end
            adcm_pkg::CSR_FAULT_THRESHOLD: begin
               threshold_in = csr_wdata[SB-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Tick processing: countdown, conversion request, fault check, reading capture
   always_comb begin
      channel_in      = channel_ff;
      settle_count_in = settle_count_ff;
      bottom_ring_in  = bottom_ring_ff;
      heater_ring_in  = heater_ring_ff;
      ring_index_in   = ring_index_ff;
      min_in          = min_ff;
      max_in          = max_ff;
      fault_in        = fault_ff;
      start_in        = start_ff;
      taken_in        = taken_ff;
      select_in       = select_ff;
      store           = 1'b0;
      if (accept) begin
         start_in  = 1'b0;
         taken_in  = 1'b0;
         select_in = req_data.median_select;
         if (!fault_ff) begin
            if (settle_count_ff != '0) begin
               settle_count_in = settle_count_ff - TB'(1);
               start_in        = (settle_count_ff == TB'(1));
            end else if (req_data.conv_done) begin
               if (req_data.adc_reading < threshold_ff) begin
                  fault_in = 1'b1;
               end else begin
                  store    = 1'b1;
                  taken_in = 1'b1;
               end
            end
         end
      end
      if (store) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (ring_index_ff == IW'(i)) begin
               if (channel_ff == adcm_pkg::CHANNEL_HEATER) begin
                  heater_ring_in[i] = req_data.adc_reading;
               end else begin
                  bottom_ring_in[i] = req_data.adc_reading;
               end
            end
         end
         // index advances after the heater reading only
         if (channel_ff == adcm_pkg::CHANNEL_HEATER) begin
            ring_index_in = (ring_index_ff == IW'(HISTORY_DEPTH - 1)) ? '0
                                                                      : ring_index_ff + IW'(1);
         end
         if (req_data.adc_reading < min_ff[channel_ff]) begin
            min_in[channel_ff] = req_data.adc_reading;
         end
         if (req_data.adc_reading > max_ff[channel_ff]) begin
            max_in[channel_ff] = req_data.adc_reading;
         end
         channel_in      = !channel_ff;
         settle_count_in = (settle_ticks_ff == '0) ? TB'(1) : settle_ticks_ff;
      end
   end

   // Ring chosen for the median, entry by entry
   always_comb begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         median_ring[i] = select_ff ? heater_ring_ff[i] : bottom_ring_ff[i];
      end
   end

   assign med_ctrl.start = (state_ff == adcm_pkg::ST_LAUNCH);

   adcm_median #(
      .DEPTH (HISTORY_DEPTH)
   ) u_median (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (med_ctrl),
      .ring_data    (median_ring),
      .stat         (med_stat),
      .median_value (median_value)
   );

   // Sequencer and output register
   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         adcm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = adcm_pkg::ST_LAUNCH;
            end
         end
         adcm_pkg::ST_LAUNCH: begin
            state_in = adcm_pkg::ST_SORT;
         end
         adcm_pkg::ST_SORT: begin
            if (med_stat.done) begin
               state_in = adcm_pkg::ST_EMIT;
            end
         end
         adcm_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.start_conversion = start_ff;
               rsp_in.channel          = channel_ff;
               rsp_in.reading_taken    = taken_ff;
               rsp_in.median_value     = median_value;
               rsp_in.bottom_min       = min_ff[adcm_pkg::CHANNEL_BOTTOM];
               rsp_in.bottom_max       = max_ff[adcm_pkg::CHANNEL_BOTTOM];
               rsp_in.heater_min       = min_ff[adcm_pkg::CHANNEL_HEATER];
               rsp_in.heater_max       = max_ff[adcm_pkg::CHANNEL_HEATER];
               rsp_in.fault            = fault_ff;
               rsp_valid_in            = 1'b1;
               state_in                = adcm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = adcm_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= adcm_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         settle_ticks_ff <= adcm_pkg::SETTLE_TICKS_RESET;
         threshold_ff    <= adcm_pkg::FAULT_THRESHOLD_RESET;
         channel_ff      <= adcm_pkg::CHANNEL_BOTTOM;
         settle_count_ff <= adcm_pkg::SETTLE_TICKS_RESET;
         ring_index_ff   <= '0;
         fault_ff        <= 1'b0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            bottom_ring_ff[i] <= '0;
            heater_ring_ff[i] <= '0;
         end
         for (int c = 0; c < 2; c++) begin
            min_ff[c] <= adcm_pkg::SAMPLE_MAX;
            max_ff[c] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         settle_ticks_ff <= settle_ticks_in;
         threshold_ff    <= threshold_in;
         channel_ff      <= channel_in;
         settle_count_ff <= settle_count_in;
         ring_index_ff   <= ring_index_in;
         fault_ff        <= fault_in;
         bottom_ring_ff  <= bottom_ring_in;
         heater_ring_ff  <= heater_ring_in;
         min_ff          <= min_in;
         max_ff          <= max_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      start_ff  <= start_in;
      taken_ff  <= taken_in;
      select_ff <= select_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      fault_ff |=> fault_ff)
      else $error("fault cleared without reset");

   a_frozen_state: assert property (@(posedge clock) disable iff (reset)
      fault_ff |=> $stable(channel_ff) && $stable(settle_count_ff) && $stable(ring_index_ff))
      else $error("scan state moved while faulted");

   a_ring_index_range: assert property (@(posedge clock) disable iff (reset)
      ring_index_ff <= IW'(HISTORY_DEPTH - 1))
      else $error("ring index out of range");

   a_start_excl_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.start_conversion && rsp_ff.reading_taken))
      else $error("conversion start and reading on the same tick");

   a_selector_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == adcm_pkg::ST_IDLE) || (state_ff == adcm_pkg::ST_LAUNCH) |-> !med_stat.busy)
      else $error("median selector busy outside a tick");

endmodule

FILE: tb/sv/tb_two_channel_adc_scan_median.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_two_channel_adc_scan_median
// Self-checking bench for the two-channel ADC scanner with median filter.
// A queue-fed driver offers tick transactions and a clocked monitor compares
// every result field against a scanner model kept inside the bench. The run
// moves through several settle / threshold settings, including a full-scale
// settle write during a long countdown, a long receiver hold-off, and ends
// by latching the fault.
// ---------------------------------------------------------------------------
module tb_two_channel_adc_scan_median;

   localparam int SB            = adcm_pkg::SAMPLE_BITS;
   localparam int TB            = adcm_pkg::SETTLE_BITS;
   localparam int IB            = adcm_pkg::CSR_INDEX_BITS;
   localparam int DB            = adcm_pkg::CSR_DATA_BITS;
   localparam int DEPTH         = adcm_pkg::HISTORY_DEPTH_DEFAULT;
   localparam int WATCHDOG_MAX  = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_TICKS  = 480;
   localparam int LONG_SETTLE   = 250;
   localparam logic [IB-1:0] CSR_UNUSED = 2'd3;

   // Idle regimes for the two channels
   localparam int PACE_RX_HEAVY = 0;   // sender idles 22%, receiver 79%
   localparam int PACE_TX_HEAVY = 1;   // sender idles 79%, receiver 22%
   localparam int PACE_FREE     = 2;   // no idling

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   adcm_pkg::req_type          req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   adcm_pkg::rsp_type          rsp_data;
   logic                       csr_write_en = 1'b0;
   logic [IB-1:0]              csr_index = '0;
   logic [DB-1:0]              csr_wdata = '0;

   two_channel_adc_scan_median u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Scanner model state and its copy of the registers
   logic [TB-1:0] settle_reg;
   logic [SB-1:0] fault_floor;
   logic          scan_channel;
   logic [TB-1:0] settle_left;
   logic [SB-1:0] bottom_ring [DEPTH];
   logic [SB-1:0] heater_ring [DEPTH];
   int            ring_pos;
   logic [SB-1:0] chan_min [2];
   logic [SB-1:0] chan_max [2];
   logic          frozen;

   adcm_pkg::req_type pending_ticks[$];
   adcm_pkg::rsp_type expected_ticks[$];

   int pace_mode = PACE_RX_HEAVY;
   bit hold_armed = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int error_count = 0;
   int tick_total = 0;
   int taken_total = 0;
   int start_total = 0;

   function automatic void clear_scanner();
      settle_reg   = adcm_pkg::SETTLE_TICKS_RESET;
      fault_floor  = adcm_pkg::FAULT_THRESHOLD_RESET;
      scan_channel = adcm_pkg::CHANNEL_BOTTOM;
      settle_left  = adcm_pkg::SETTLE_TICKS_RESET;
      for (int i = 0; i < DEPTH; i++) begin
         bottom_ring[i] = '0;
         heater_ring[i] = '0;
      end
      ring_pos = 0;
      chan_min[adcm_pkg::CHANNEL_BOTTOM] = adcm_pkg::SAMPLE_MAX;
      chan_min[adcm_pkg::CHANNEL_HEATER] = adcm_pkg::SAMPLE_MAX;
      chan_max[adcm_pkg::CHANNEL_BOTTOM] = '0;
      chan_max[adcm_pkg::CHANNEL_HEATER] = '0;
      frozen = 1'b0;
   endfunction

   // Middle rank: the entry with at most DEPTH/2 smaller and more than DEPTH/2
   // not-larger neighbors
   function automatic logic [SB-1:0] ring_median(input logic sel);
      logic [SB-1:0] v [DEPTH];
      logic [SB-1:0] m;
      int below;
      int not_above;
      m = '0;
      for (int i = 0; i < DEPTH; i++)
         v[i] = (sel == adcm_pkg::CHANNEL_HEATER) ? heater_ring[i] : bottom_ring[i];
      for (int i = 0; i < DEPTH; i++) begin
         below = 0;
         not_above = 0;
         for (int j = 0; j < DEPTH; j++) begin
            if (v[j] < v[i]) below++;
            if (v[j] <= v[i]) not_above++;
         end
         if (below <= DEPTH / 2 && DEPTH / 2 < not_above)
            m = v[i];
      end
      return m;
   endfunction

   // Advance the scanner by one tick and build the result it should report
   function automatic adcm_pkg::rsp_type scan_tick(input adcm_pkg::req_type t);
      adcm_pkg::rsp_type r;
      logic    start;
      logic    taken;
      logic    ch;
      start = 1'b0;
      taken = 1'b0;
      if (!frozen) begin
         if (settle_left != 0) begin
            settle_left = settle_left - 1'b1;
            if (settle_left == 0) start = 1'b1;
         end else if (t.conv_done) begin
            if (t.adc_reading < fault_floor) begin
               frozen = 1'b1;
            end else begin
               ch = scan_channel;
               if (ch == adcm_pkg::CHANNEL_HEATER) begin
                  heater_ring[ring_pos] = t.adc_reading;
                  ring_pos = (ring_pos == DEPTH - 1) ? 0 : ring_pos + 1;
               end else begin
                  bottom_ring[ring_pos] = t.adc_reading;
               end
               if (t.adc_reading < chan_min[ch]) chan_min[ch] = t.adc_reading;
               if (t.adc_reading > chan_max[ch]) chan_max[ch] = t.adc_reading;
               scan_channel = ~ch;
               settle_left = (settle_reg == 0) ? TB'(1) : settle_reg;
               taken = 1'b1;
            end
         end
      end
      r.start_conversion = start;
      r.channel          = scan_channel;
      r.reading_taken    = taken;
      r.median_value     = ring_median(t.median_select);
      r.bottom_min       = chan_min[adcm_pkg::CHANNEL_BOTTOM];
      r.bottom_max       = chan_max[adcm_pkg::CHANNEL_BOTTOM];
      r.heater_min       = chan_min[adcm_pkg::CHANNEL_HEATER];
      r.heater_max       = chan_max[adcm_pkg::CHANNEL_HEATER];
      r.fault            = frozen;
      tick_total++;
      taken_total += taken;
      start_total += start;
      return r;
   endfunction

   function automatic void queue_tick(input logic done, input logic [SB-1:0] reading,
                                      input logic sel);
      adcm_pkg::req_type t;
      t.conv_done     = done;
      t.adc_reading   = reading;
      t.median_select = sel;
      pending_ticks.push_back(t);
   endfunction

   // Random tick; a done reading never falls below the floor so the block
   // stays out of fault
   function automatic void queue_random_tick(input logic [SB-1:0] floor_val);
      logic          done;
      logic [SB-1:0] lo;
      logic [SB-1:0] reading;
      done = ($urandom_range(0, 3) != 0);
      lo = done ? floor_val : '0;
      case ($urandom_range(0, 9))
         0:       reading = lo;
         1:       reading = adcm_pkg::SAMPLE_MAX;
         default: reading = SB'($urandom_range(lo, adcm_pkg::SAMPLE_MAX));
      endcase
      queue_tick(done, reading, 1'($urandom_range(0, 1)));
   endfunction

   function automatic bit sender_pause();
      case (pace_mode)
         PACE_RX_HEAVY: return $urandom_range(0, 99) < 22;
         PACE_TX_HEAVY: return $urandom_range(0, 99) < 79;
         default:       return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_pause();
      case (pace_mode)
         PACE_RX_HEAVY: return $urandom_range(0, 99) < 79;
         PACE_TX_HEAVY: return $urandom_range(0, 99) < 22;
         default:       return 1'b0;
      endcase
   endfunction

   task automatic check_field(input string name, input logic [SB-1:0] want,
                              input logic [SB-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Register write; the model picks it up on the same edge
   task automatic write_csr(input logic [IB-1:0] idx, input logic [DB-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == adcm_pkg::CSR_SETTLE_TICKS)
         settle_reg = value;
      else if (idx == adcm_pkg::CSR_FAULT_THRESHOLD)
         fault_floor = value[SB-1:0];
   endtask

   // Wait until every queued tick has gone through and its result came back
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_ticks.size() != 0 || expected_ticks.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Driver: offers the head of the pending queue, holds it while stalled
   always @(posedge clock) begin : drive_proc
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_ticks.push_back(scan_tick(pending_ticks.pop_front()));
         if (!(req_valid && req_stall)) begin
            if (pending_ticks.size() != 0 && !sender_pause()) begin
               req_valid <= 1'b1;
               req_data  <= pending_ticks[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transaction, drives the receiver stall
   always @(posedge clock) begin : collect_proc
      adcm_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_ticks.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing outstanding, actual %h", $time, rsp_data);
            end else begin
               want = expected_ticks.pop_front();
               check_field("start_conversion", want.start_conversion, rsp_data.start_conversion);
               check_field("channel", want.channel, rsp_data.channel);
               check_field("reading_taken", want.reading_taken, rsp_data.reading_taken);
               check_field("median_value", want.median_value, rsp_data.median_value);
               check_field("bottom_min", want.bottom_min, rsp_data.bottom_min);
               check_field("bottom_max", want.bottom_max, rsp_data.bottom_max);
               check_field("heater_min", want.heater_min, rsp_data.heater_min);
               check_field("heater_max", want.heater_max, rsp_data.heater_max);
               check_field("fault", want.fault, rsp_data.fault);
            end
         end
         // long hold-off lets the output register fill and back up the input
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  <= HOLD_CYCLES - 1;
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall <= receiver_pause();
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin : watchdog_proc
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      logic [SB-1:0] floor_val;
      logic [TB-1:0] settle_val;
      clear_scanner();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings (settle 2, threshold 50)
      queue_tick(1'b1, 10'd0,   adcm_pkg::CHANNEL_BOTTOM);  // done while settling, ignored
      queue_tick(1'b0, 10'h3FF, adcm_pkg::CHANNEL_HEATER);  // countdown hits zero
      queue_tick(1'b0, 10'd0,   adcm_pkg::CHANNEL_BOTTOM);  // waiting, no done
      queue_tick(1'b1, 10'd50,  adcm_pkg::CHANNEL_BOTTOM);  // equal to threshold: stored
      queue_tick(1'b1, 10'h3FF, adcm_pkg::CHANNEL_HEATER);
      queue_tick(1'b0, 10'h000, adcm_pkg::CHANNEL_HEATER);
      queue_tick(1'b1, 10'h3FF, adcm_pkg::CHANNEL_HEATER);  // heater reading, ring advances
      queue_tick(1'b0, 10'h155, adcm_pkg::CHANNEL_BOTTOM);
      queue_tick(1'b1, 10'h3FF, adcm_pkg::CHANNEL_HEATER);
      queue_tick(1'b1, 10'h155, adcm_pkg::CHANNEL_BOTTOM);
      queue_tick(1'b0, 10'h000, adcm_pkg::CHANNEL_HEATER);
      queue_tick(1'b0, 10'h000, adcm_pkg::CHANNEL_BOTTOM);
      queue_tick(1'b1, 10'h2AA, adcm_pkg::CHANNEL_HEATER);
      queue_tick(1'b1, 10'h2AA, adcm_pkg::CHANNEL_BOTTOM);
      queue_tick(1'b1, 10'h155, adcm_pkg::CHANNEL_HEATER);
      queue_tick(1'b1, 10'h3FE, adcm_pkg::CHANNEL_BOTTOM);
      wait_drained();

      // Shortest settle, no threshold; unused index must not disturb anything
      write_csr(adcm_pkg::CSR_SETTLE_TICKS, 16'd1);
      write_csr(adcm_pkg::CSR_FAULT_THRESHOLD, 16'd0);
      write_csr(CSR_UNUSED, 16'hFFFF);
      for (int i = 0; i < RANDOM_TICKS; i++) queue_random_tick(fault_floor);
      wait_drained();

      // Settle of zero behaves as one; threshold with junk in the upper bits
      pace_mode = PACE_TX_HEAVY;
      floor_val = SB'($urandom_range(1, 200));
      write_csr(adcm_pkg::CSR_SETTLE_TICKS, 16'd0);
      write_csr(adcm_pkg::CSR_FAULT_THRESHOLD, {6'($urandom), floor_val});
      for (int i = 0; i < RANDOM_TICKS; i++) queue_random_tick(fault_floor);
      wait_drained();

      // Longer settle, full rate, receiver holds off at the start
      pace_mode = PACE_FREE;
      settle_val = TB'($urandom_range(2, 6));
      floor_val = SB'($urandom_range(0, 100));
      write_csr(adcm_pkg::CSR_SETTLE_TICKS, settle_val);
      write_csr(adcm_pkg::CSR_FAULT_THRESHOLD, {6'd0, floor_val});
      hold_armed = 1'b1;
      for (int i = 0; i < RANDOM_TICKS; i++) queue_random_tick(fault_floor);
      wait_drained();

      // Fill both rings with full scale before the long countdown
      write_csr(adcm_pkg::CSR_SETTLE_TICKS, 16'd1);
      write_csr(adcm_pkg::CSR_FAULT_THRESHOLD, 16'd0);
      for (int i = 0; i < 40; i++)
         queue_tick(1'b1, adcm_pkg::SAMPLE_MAX, 1'($urandom_range(0, 1)));
      wait_drained();

      // Long settle: one reading reloads it, then a full-scale write must
      // leave the running countdown alone
      write_csr(adcm_pkg::CSR_SETTLE_TICKS, TB'(LONG_SETTLE));
      for (int i = 0; i < 3; i++)
         queue_tick(1'b1, adcm_pkg::SAMPLE_MAX, 1'($urandom_range(0, 1)));
      wait_drained();
      write_csr(adcm_pkg::CSR_SETTLE_TICKS, 16'hFFFF);
      for (int i = 0; i < LONG_SETTLE; i++)
         queue_tick(1'b0, SB'($urandom), 1'($urandom_range(0, 1)));
      wait_drained();

      // Top threshold: full scale still stored, one below latches the fault
      write_csr(adcm_pkg::CSR_SETTLE_TICKS, 16'd1);
      write_csr(adcm_pkg::CSR_FAULT_THRESHOLD, 16'hFFFF);
      queue_tick(1'b1, adcm_pkg::SAMPLE_MAX, adcm_pkg::CHANNEL_BOTTOM);
      queue_tick(1'b1, 10'h3FE, adcm_pkg::CHANNEL_HEATER);
      queue_tick(1'b1, 10'h3FE, adcm_pkg::CHANNEL_BOTTOM);
      for (int i = 0; i < 10; i++)
         queue_tick(1'($urandom_range(0, 1)), SB'($urandom), 1'($urandom_range(0, 1)));
      wait_drained();

      $display("Covered %0d ticks: %0d readings stored, %0d conversion starts,", tick_total,
               taken_total, start_total);
      $display("settle 0..65535, threshold 0..1023, fault latched %0d, errors %0d", frozen,
               error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
